/* rtl/core/hts_pkg.sv */
package hts_pkg;

    localparam int HALF_W      = 16;
    localparam int HALF_MANT_W = 10;
    localparam int HALF_EXP_W  = 5;
    localparam int SGL_W       = 32;
    localparam int SGL_EXP_W   = 8;
    localparam int SHIFT_W     = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [SGL_EXP_W-1:0]  REBIAS_ADD   = 8'd112;
    localparam logic [SGL_EXP_W-1:0]  SUBNORM_BASE = 8'd113;
    localparam logic [SGL_EXP_W-1:0]  SGL_EXP_ALL  = 8'hff;
    localparam logic [HALF_EXP_W-1:0] HALF_EXP_ALL = 5'h1f;
    localparam logic [SGL_W-2:0]      FLT_MAX_MAG  = 31'h7f7fffff;

    localparam logic signed [SGL_W-1:0] MIN_LIMIT_RST = 32'shff7fffff;
    localparam logic signed [SGL_W-1:0] MAX_LIMIT_RST = 32'sh7f7fffff;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BELOW   = 3'd1,
        ST_ABOVE   = 3'd2,
        ST_INF_REJ = 3'd3,
        ST_NAN     = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN   = 2'd0,
        CFG_MAX   = 2'd1,
        CFG_ALLOW = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                   sign;
        logic [HALF_EXP_W-1:0]  expo;
        logic [HALF_MANT_W-1:0] mant;
        logic                   is_special;
        logic                   is_zero;
        logic [SHIFT_W-1:0]     shift;
    } t_dec;

    typedef struct packed {
        logic [SGL_W-1:0]        bits;
        logic signed [SGL_W-1:0] cmp;
        logic                    is_nan;
        logic                    is_inf;
    } t_cvt;

endpackage

/* rtl/core/half_to_single_with_range_check.sv */
// Converts one IEEE half-precision word per request into single-precision bits and checks the
// result against the programmed limits, reporting status 0 ok, 1 below minimum, 2 above maximum,
// 3 infinity rejected or 4 not a number. The block takes one request per cycle unless its output
// stalls, and each result passes through the three register stages of decode with
// leading-zero count, normalize and signed limit compare. The limits are single-precision bit
// patterns read as signed integers, and they should be written only while the block is empty.
module half_to_single_with_range_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [hts_pkg::HALF_W-1:0]          i_half_bits,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [hts_pkg::SGL_W-1:0]           o_single_bits,
    output logic [2:0]                          o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hts_pkg::SGL_W-1:0]           i_cfg_data
);
    import hts_pkg::*;

    logic signed [SGL_W-1:0] r_min_limit_bits;
    logic signed [SGL_W-1:0] r_max_limit_bits;
    logic                    r_allow_infinity;

    logic    dec_valid;
    logic    dec_ready;
    t_dec    dec;
    logic    cvt_valid;
    logic    cvt_ready;
    t_cvt    cvt;
    t_status status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_limit_bits <= MIN_LIMIT_RST;
            r_max_limit_bits <= MAX_LIMIT_RST;
            r_allow_infinity <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN:   r_min_limit_bits <= i_cfg_data;
                CFG_MAX:   r_max_limit_bits <= i_cfg_data;
                CFG_ALLOW: r_allow_infinity <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    hts_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_half_bits (i_half_bits),
        .o_valid     (dec_valid),
        .i_ready     (dec_ready),
        .o_dec       (dec)
    );

    hts_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_dec   (dec),
        .o_valid (cvt_valid),
        .i_ready (cvt_ready),
        .o_cvt   (cvt)
    );

    hts_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (cvt_valid),
        .o_ready       (cvt_ready),
        .i_cvt         (cvt),
        .i_min_limit   (r_min_limit_bits),
        .i_max_limit   (r_max_limit_bits),
        .i_allow_inf   (r_allow_infinity),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_single_bits (o_single_bits),
        .o_status      (status)
    );

    assign o_status = status;

endmodule

/* rtl/core/hts_decode.sv */
module hts_decode (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [hts_pkg::HALF_W-1:0]       i_half_bits,
    output logic                             o_valid,
    input  logic                             i_ready,
    output hts_pkg::t_dec                    o_dec
);
    import hts_pkg::*;

    logic r_vld;
    t_dec r_dec;
    t_dec n_dec;

    always_comb begin
        n_dec.sign       = i_half_bits[HALF_W-1];
        n_dec.expo       = i_half_bits[HALF_W-2:HALF_MANT_W];
        n_dec.mant       = i_half_bits[HALF_MANT_W-1:0];
        n_dec.is_special = (n_dec.expo == HALF_EXP_ALL);
        n_dec.is_zero    = (i_half_bits[HALF_W-2:0] == '0);
        n_dec.shift      = '0;
        for (int i = 0; i < HALF_MANT_W; i++) begin
            if (n_dec.mant[i]) begin
                n_dec.shift = SHIFT_W'(HALF_MANT_W - i);
            end
        end
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_vld;
    assign o_dec   = r_dec;

endmodule

/* rtl/core/hts_norm.sv */
module hts_norm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  hts_pkg::t_dec i_dec,
    output logic          o_valid,
    input  logic          i_ready,
    output hts_pkg::t_cvt o_cvt
);
    import hts_pkg::*;

    logic                   r_vld;
    t_cvt                   r_cvt;
    t_cvt                   n_cvt;
    logic [SGL_EXP_W-1:0]   expo8;
    logic [HALF_MANT_W-1:0] mant10;

    always_comb begin
        mant10 = i_dec.mant;
        if (i_dec.is_special) begin
            expo8 = SGL_EXP_ALL;
        end else if (i_dec.expo != '0) begin
            expo8 = SGL_EXP_W'(i_dec.expo) + REBIAS_ADD;
        end else if (i_dec.mant != '0) begin
            expo8  = SUBNORM_BASE - SGL_EXP_W'(i_dec.shift);
            mant10 = i_dec.mant << i_dec.shift;
        end else begin
            expo8 = '0;
        end
        n_cvt.bits   = {i_dec.sign, expo8, mant10, 13'd0};
        n_cvt.is_nan = i_dec.is_special && (i_dec.mant != '0);
        n_cvt.is_inf = i_dec.is_special && (i_dec.mant == '0);
        if (n_cvt.is_inf) begin
            n_cvt.cmp = {i_dec.sign, FLT_MAX_MAG};
        end else if (i_dec.is_zero) begin
            n_cvt.cmp = '0;
        end else begin
            n_cvt.cmp = n_cvt.bits;
        end
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cvt <= n_cvt;
        end
    end

    assign o_valid = r_vld;
    assign o_cvt   = r_cvt;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_cvt.is_nan && !r_cvt.is_inf |-> r_cvt.bits[30:23] != SGL_EXP_ALL)
        else $error("Finite value converted with an all-ones exponent.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_cvt.bits[30:23] == '0 |-> r_cvt.bits[22:0] == '0)
        else $error("Converted value is a single-precision subnormal.");

endmodule

/* rtl/core/hts_check.sv */
module hts_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  hts_pkg::t_cvt                       i_cvt,
    input  logic signed [hts_pkg::SGL_W-1:0]    i_min_limit,
    input  logic signed [hts_pkg::SGL_W-1:0]    i_max_limit,
    input  logic                                i_allow_inf,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [hts_pkg::SGL_W-1:0]           o_single_bits,
    output hts_pkg::t_status                    o_status
);
    import hts_pkg::*;

    logic             r_vld;
    logic [SGL_W-1:0] r_bits;
    t_status          r_status;
    t_status          n_status;

    always_comb begin
        if (i_cvt.is_nan) begin
            n_status = ST_NAN;
        end else if (i_cvt.is_inf && !i_allow_inf) begin
            n_status = ST_INF_REJ;
        end else if (i_cvt.cmp < i_min_limit) begin
            n_status = ST_BELOW;
        end else if (i_cvt.cmp > i_max_limit) begin
            n_status = ST_ABOVE;
        end else begin
            n_status = ST_OK;
        end
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bits   <= i_cvt.bits;
            r_status <= n_status;
        end
    end

    assign o_valid       = r_vld;
    assign o_single_bits = r_bits;
    assign o_status      = r_status;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_status == ST_NAN |-> r_bits[30:23] == SGL_EXP_ALL && r_bits[22:0] != '0)
        else $error("Not-a-number status on a non-NaN pattern.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_status == ST_INF_REJ |-> r_bits[30:23] == SGL_EXP_ALL && r_bits[22:0] == '0)
        else $error("Infinity rejected on a non-infinite pattern.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_bits[30:0] == '0 |-> r_status != ST_NAN && r_status != ST_INF_REJ)
        else $error("Zero flagged as a special value.");

endmodule

/* tb/sv/tb_half_to_single_with_range_check.sv */
`timescale 1ns / 100ps

module tb_half_to_single_with_range_check;
    import hts_pkg::*;

    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 80;
    localparam int RAND_ITEMS     = 170;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [4:0]  HALF_EXP_ONES = 5'h1f;
    localparam logic [7:0]  EXP_REBIAS    = 8'd112;
    localparam logic [7:0]  SUBN_EXP_TOP  = 8'd113;
    localparam logic [31:0] FMAX_POS      = 32'h7f7fffff;
    localparam logic [31:0] FMAX_NEG      = 32'hff7fffff;

    typedef struct {
        logic [15:0] half;
        logic [31:0] bits;
        t_status     status;
    } t_conv_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [HALF_W-1:0]    i_half_bits = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [SGL_W-1:0]     o_single_bits;
    logic [2:0]           o_status;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SGL_W-1:0]     i_cfg_data = '0;

    half_to_single_with_range_check dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_half_bits   (i_half_bits),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_single_bits (o_single_bits),
        .o_status      (o_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    logic signed [31:0] min_lim_m = MIN_LIMIT_RST;
    logic signed [31:0] max_lim_m = MAX_LIMIT_RST;
    logic               allow_inf_m = 1'b0;

    logic [15:0]  half_q[$];
    t_conv_result single_q[$];
    t_conv_result accepted_item;
    t_conv_result next_exp;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    logic        pressure_on = 1'b0;
    logic        pressure_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_cnt = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned result_cnt = 0;
    int unsigned settings_cnt = 1;
    int unsigned status_seen[5];
    logic [15:0] lo_src = 16'h0000;
    logic [15:0] hi_src = 16'h7bff;

    logic [15:0] corner_halves[22] = '{
        16'h0000, 16'h8000, 16'h0001, 16'h8001, 16'h03ff, 16'h83ff,
        16'h0200, 16'h0155, 16'h0400, 16'h8400, 16'h3c00, 16'hbc00,
        16'h7bff, 16'hfbff, 16'h7c00, 16'hfc00, 16'h7c01, 16'h7e00,
        16'hffff, 16'h7fff, 16'h5555, 16'haaaa
    };

    function automatic logic [31:0] convert_half_word(input logic [15:0] h);
        logic [4:0]  e;
        logic [10:0] m;
        logic [7:0]  se;
        logic [7:0]  sh;
        e  = h[14:10];
        m  = {1'b0, h[9:0]};
        se = 8'd0;
        sh = 8'd0;
        if (e == HALF_EXP_ONES) begin
            se = 8'hff;
        end else if (e != 5'd0) begin
            se = {3'b000, e} + EXP_REBIAS;
        end else if (m != 11'd0) begin
            while (!m[10]) begin
                m  = m << 1;
                sh = sh + 8'd1;
            end
            se = SUBN_EXP_TOP - sh;
        end
        return {h[15], se, m[9:0], 13'b0};
    endfunction

    function automatic t_status range_status(input logic [15:0] h, input logic [31:0] bits);
        logic signed [31:0] cmp;
        cmp = $signed(bits);
        if (h[14:10] == HALF_EXP_ONES) begin
            if (h[9:0] != 10'd0) return ST_NAN;
            if (!allow_inf_m) return ST_INF_REJ;
            cmp = h[15] ? $signed(FMAX_NEG) : $signed(FMAX_POS);
        end else if (h[14:0] == 15'd0) begin
            cmp = '0;
        end
        if (cmp < min_lim_m) return ST_BELOW;
        if (cmp > max_lim_m) return ST_ABOVE;
        return ST_OK;
    endfunction

    function automatic logic [15:0] pick_half();
        logic [9:0]  mant;
        logic [15:0] h;
        mant = 10'($urandom);
        h    = 16'($urandom);
        case ($urandom_range(9))
            0: h = {h[15], 5'd0, mant};
            1: begin
                mant = 10'($urandom_range(3));
                h = {h[15], 5'd0, mant};
            end
            2: h = {h[15], HALF_EXP_ONES, ($urandom_range(1) != 0) ? 10'd0 : mant};
            3: h = lo_src + 16'($urandom_range(2)) - 16'd1;
            4: h = hi_src + 16'($urandom_range(2)) - 16'd1;
            default: ;
        endcase
        return h;
    endfunction

    function automatic logic [15:0] pick_finite_half();
        logic [15:0] h;
        h = 16'($urandom);
        h[14:10] = 5'($urandom_range(30));
        return h;
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == TIMEOUT_CYCLES) begin
            $display("half_to_single_with_range_check test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_half_bits <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                accepted_item.half   = i_half_bits;
                accepted_item.bits   = convert_half_word(i_half_bits);
                accepted_item.status = range_status(i_half_bits, accepted_item.bits);
                single_q.push_back(accepted_item);
                accepted_cnt++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (half_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_in_valid  <= 1'b1;
                    i_half_bits <= half_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left   <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                result_cnt++;
                if (o_status < 3'd5) status_seen[o_status]++;
                if (single_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: result with no request pending: expected none, got %08h/%0d",
                             $time, o_single_bits, o_status);
                end else begin
                    next_exp = single_q.pop_front();
                    if (o_single_bits !== next_exp.bits) begin
                        mismatch_cnt++;
                        $display("%0t: single_bits for half %04h: expected %08h, got %08h",
                                 $time, next_exp.half, next_exp.bits, o_single_bits);
                    end
                    if (o_status !== next_exp.status) begin
                        mismatch_cnt++;
                        $display("%0t: status for half %04h: expected %0d, got %0d",
                                 $time, next_exp.half, next_exp.status, o_status);
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (pressure_on && !pressure_done && o_out_valid) begin
                hold_left     <= HOLD_CYCLES;
                pressure_done <= 1'b1;
                i_out_ready   <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MIN:   min_lim_m = data;
            CFG_MAX:   max_lim_m = data;
            CFG_ALLOW: allow_inf_m = data[0];
            default:   ;
        endcase
    endtask

    task automatic apply_limits(input logic [31:0] lo, input logic [31:0] hi, input logic allow);
        write_reg(CFG_MIN, lo);
        write_reg(CFG_MAX, hi);
        write_reg(CFG_ALLOW, {$urandom} & 32'hffff_fffe | {31'd0, allow});
        settings_cnt++;
    endtask

    task automatic wait_drain();
        while (half_q.size() != 0 || i_in_valid || single_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int unsigned n);
        repeat (n) half_q.push_back(pick_half());
        wait_drain();
    endtask

    task automatic random_limits(input logic allow);
        lo_src = pick_finite_half();
        hi_src = pick_finite_half();
        apply_limits(convert_half_word(lo_src), convert_half_word(hi_src), allow);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        tx_idle_pct <= 8;
        rx_idle_pct <= 51;

        foreach (corner_halves[k]) half_q.push_back(corner_halves[k]);
        wait_drain();

        apply_limits(32'h8000_0000, 32'h7fff_ffff, 1'b1);
        write_reg(CFG_UNUSED, $urandom);
        half_q.push_back(16'h7c00);
        half_q.push_back(16'hfc00);
        half_q.push_back(16'hfe01);
        half_q.push_back(16'h8000);
        wait_drain();

        random_limits(1'b1);
        pressure_on <= 1'b1;
        run_random(RAND_ITEMS);

        tx_idle_pct <= 51;
        rx_idle_pct <= 8;
        random_limits(1'b0);
        run_random(RAND_ITEMS);

        lo_src = pick_finite_half();
        hi_src = pick_finite_half();
        lo_src[15] = 1'b0;
        hi_src[15] = 1'b0;
        if (lo_src < hi_src) begin
            apply_limits(convert_half_word(hi_src), convert_half_word(lo_src), 1'b1);
        end else begin
            apply_limits(convert_half_word(lo_src), convert_half_word(hi_src), 1'b1);
        end
        run_random(RAND_ITEMS);

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        apply_limits(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        run_random(RAND_ITEMS);

        lo_src = 16'hfbff;
        hi_src = 16'h7bff;
        apply_limits(FMAX_NEG, FMAX_POS, 1'b1);
        run_random(RAND_ITEMS);

        $display("Converted %0d half words (%0d results) under %0d limit settings.",
                 accepted_cnt, result_cnt, settings_cnt);
        $display("Status mix: ok %0d, below %0d, above %0d, inf rejected %0d, nan %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (mismatch_cnt == 0) begin
            $display("half_to_single_with_range_check test passed");
        end else begin
            $display("half_to_single_with_range_check test failed");
        end
        $finish;
    end

endmodule
